FILE: src/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared constants and types for the delimiter string splitter.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Separator storage and limits
  localparam int SEP_BYTES   = 16;
  localparam int MAX_SEP     = 10;
  localparam int CNT_W       = 5;
  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [1:0] REG_SEP_LOW  = 2'd0;
  localparam logic [1:0] REG_SEP_HIGH = 2'd1;
  localparam logic [1:0] REG_SEP_LEN  = 2'd2;

  typedef struct packed {
    logic [8*SEP_BYTES-1:0] sep_bytes;  // byte 0 in the lowest bits
    logic [CNT_W-1:0]       sep_len;    // effective length, 1 to MaxSep
  } dss_cfg_t;

  // One classified input byte, as handed from the front to the back
  typedef struct packed {
    logic [7:0]       data;      // the input byte
    logic [CNT_W-1:0] sep_cnt;   // held separator bytes to release first
    logic             has_b;     // release the input byte after them
    logic             marker;    // emit an end marker only
    logic             closes;    // final result closes the token
    logic [31:0]      number;    // token number for every result
  } dss_desc_t;

endpackage

FILE: src/dss_if.sv
// ----------------------------------------------------------------------------
// dss_if
// Valid/ready stream interfaces for input bytes and token results.
// ----------------------------------------------------------------------------
interface dss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface dss_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  token_byte;
  logic        byte_valid;
  logic        token_end;
  logic [31:0] token_number;
  logic        last_result;

  modport source (output valid, output token_byte, output byte_valid,
                  output token_end, output token_number, output last_result,
                  input ready);
  modport sink (input valid, input token_byte, input byte_valid,
                input token_end, input token_number, input last_result,
                output ready);
endinterface

FILE: src/dss_regs.sv
// ----------------------------------------------------------------------------
// dss_regs
// APB register file: separator bytes and separator length.
// ----------------------------------------------------------------------------
module dss_regs #(
  parameter int MaxSep = dss_pkg::MAX_SEP
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dss_pkg::ADDR_W-1:0]  paddr,
  input  logic [dss_pkg::DATA_W-1:0]  pwdata,
  output logic [dss_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output dss_pkg::dss_cfg_t           cfg
);

  logic [63:0]               sep_bytes_low;
  logic [63:0]               sep_bytes_high;
  logic [dss_pkg::CNT_W-1:0] sep_length;
  logic [1:0]                reg_idx;
  logic                      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dss_pkg::ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_bytes_low  <= '0;
      sep_bytes_high <= '0;
      sep_length     <= dss_pkg::CNT_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        dss_pkg::REG_SEP_LOW:  sep_bytes_low  <= pwdata;
        dss_pkg::REG_SEP_HIGH: sep_bytes_high <= pwdata;
        dss_pkg::REG_SEP_LEN:  sep_length     <= pwdata[dss_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dss_pkg::REG_SEP_LOW:  prdata = sep_bytes_low;
      dss_pkg::REG_SEP_HIGH: prdata = sep_bytes_high;
      dss_pkg::REG_SEP_LEN:  prdata = dss_pkg::DATA_W'(sep_length);
      default:               prdata = '0;
    endcase
  end

  // Clamp the length into 1..MaxSep
  always_comb begin
    cfg.sep_bytes = {sep_bytes_high, sep_bytes_low};
    if (sep_length == '0) begin
      cfg.sep_len = dss_pkg::CNT_W'(1);
    end else if (sep_length > dss_pkg::CNT_W'(MaxSep)) begin
      cfg.sep_len = dss_pkg::CNT_W'(MaxSep);
    end else begin
      cfg.sep_len = sep_length;
    end
  end

endmodule

FILE: src/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front
// Accepts input bytes, tracks the partial separator match with a KMP-style
// fallback and pushes one descriptor per byte that releases results.
// ----------------------------------------------------------------------------
module dss_front #(
  parameter int MaxSep = dss_pkg::MAX_SEP
) (
  input  logic               clk,
  input  logic               rst,
  input  dss_pkg::dss_cfg_t  cfg,
  dss_in_if.sink             data_in,
  input  logic               q_full,
  output logic               q_push,
  output dss_pkg::dss_desc_t q_desc
);

  localparam int IdxW = (MaxSep > 1) ? $clog2(MaxSep) : 1;

  logic [dss_pkg::CNT_W-1:0] match_length;
  logic [dss_pkg::CNT_W-1:0] match_length_next;
  logic [31:0]               token_counter;
  logic [31:0]               token_counter_next;

  logic [7:0]                sep [MaxSep];
  logic [dss_pkg::CNT_W-1:0] mm;
  logic [IdxW-1:0]           mm_idx;
  logic                      accept;
  logic                      hit;
  logic                      full_match;
  logic [MaxSep-1:0]         border [MaxSep];
  logic [MaxSep-1:0]         brow;
  logic [MaxSep-1:0]         cand;
  logic [dss_pkg::CNT_W-1:0] k;

  assign data_in.ready = !q_full;
  assign accept        = data_in.valid && data_in.ready;

  always_comb begin
    for (int i = 0; i < MaxSep; i++) begin
      sep[i] = cfg.sep_bytes[8*i +: 8];
    end
  end

  // Cut a held count that no longer fits a shorter separator
  assign mm         = (match_length >= cfg.sep_len) ? cfg.sep_len - dss_pkg::CNT_W'(1)
                                                    : match_length;
  assign mm_idx     = mm[IdxW-1:0];
  assign hit        = (data_in.data_byte == sep[mm_idx]);
  assign full_match = hit && (mm + dss_pkg::CNT_W'(1) == cfg.sep_len);

  // border[mv][i]: with mv bytes held, the last i-1 held bytes equal the
  // first i-1 separator bytes
  always_comb begin
    for (int mv = 0; mv < MaxSep; mv++) begin
      for (int i = 0; i < MaxSep; i++) begin
        border[mv][i] = 1'b0;
        if (i > 0 && i <= mv) begin
          border[mv][i] = 1'b1;
          for (int j = 0; j < i - 1; j++) begin
            if (sep[mv + 1 - i + j] != sep[j]) begin
              border[mv][i] = 1'b0;
            end
          end
        end
      end
    end
  end

  assign brow = border[mm_idx];

  // Keep the longest suffix that is still a separator prefix
  always_comb begin
    k = '0;
    for (int i = 0; i < MaxSep; i++) begin
      cand[i] = 1'b0;
      if (i > 0) begin
        cand[i] = brow[i] && (data_in.data_byte == sep[i-1]);
      end
      if (cand[i]) begin
        k = dss_pkg::CNT_W'(i);
      end
    end
  end

  always_comb begin
    match_length_next  = match_length;
    token_counter_next = token_counter;
    q_push             = 1'b0;
    q_desc.data        = data_in.data_byte;
    q_desc.sep_cnt     = mm;
    q_desc.has_b       = 1'b1;
    q_desc.marker      = 1'b0;
    q_desc.closes      = 1'b0;
    q_desc.number      = token_counter;

    if (full_match) begin
      q_desc.sep_cnt    = '0;
      q_desc.has_b      = 1'b0;
      q_desc.marker     = 1'b1;
      q_desc.closes     = 1'b1;
      match_length_next = '0;
      if (data_in.buffer_end) begin
        token_counter_next = '0;
      end else if (token_counter != '1) begin
        token_counter_next = token_counter + 32'd1;
      end
      q_push = accept;
    end else if (data_in.buffer_end) begin
      q_desc.closes      = 1'b1;
      match_length_next  = '0;
      token_counter_next = '0;
      q_push             = accept;
    end else if (hit) begin
      match_length_next = mm + dss_pkg::CNT_W'(1);
    end else begin
      if (k != '0) begin
        q_desc.sep_cnt = mm + dss_pkg::CNT_W'(1) - k;
        q_desc.has_b   = 1'b0;
      end
      match_length_next = k;
      q_push            = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_length  <= '0;
      token_counter <= '0;
    end else if (accept) begin
      match_length  <= match_length_next;
      token_counter <= token_counter_next;
    end
  end

  hold_below_max: assert property (@(posedge clk) disable iff (rst)
    match_length < dss_pkg::CNT_W'(MaxSep))
    else $error("held count reached the separator limit");

  push_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_desc.marker || q_desc.has_b || q_desc.sep_cnt != '0))
    else $error("descriptor pushed with no results");

  marker_alone: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_desc.marker) |-> (!q_desc.has_b && q_desc.sep_cnt == '0 && q_desc.closes))
    else $error("end marker descriptor carries bytes");

endmodule

FILE: src/dss_fifo.sv
// ----------------------------------------------------------------------------
// dss_fifo
// Small register queue of descriptors between the front and the back.
// ----------------------------------------------------------------------------
module dss_fifo #(
  parameter int Depth = dss_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dss_pkg::dss_desc_t push_desc,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output dss_pkg::dss_desc_t head_desc
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dss_pkg::dss_desc_t store [Depth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_desc  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");

  no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

FILE: src/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back
// Expands each descriptor into its results, one per cycle while the output
// is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module dss_back (
  input  logic               clk,
  input  logic               rst,
  input  dss_pkg::dss_cfg_t  cfg,
  input  logic               q_valid,
  input  dss_pkg::dss_desc_t q_desc,
  output logic               q_pop,
  dss_out_if.source          token_out
);

  logic [7:0]                sep [dss_pkg::SEP_BYTES];
  logic [dss_pkg::CNT_W-1:0] pos;
  logic [dss_pkg::CNT_W-1:0] total;
  logic                      last;
  logic                      load;
  logic [7:0]                nxt_byte;
  logic                      nxt_valid;

  logic                      out_valid;
  logic [7:0]                out_byte;
  logic                      out_byte_valid;
  logic                      out_end;
  logic [31:0]               out_number;
  logic                      out_last;

  always_comb begin
    for (int i = 0; i < dss_pkg::SEP_BYTES; i++) begin
      sep[i] = cfg.sep_bytes[8*i +: 8];
    end
  end

  assign total = q_desc.sep_cnt + dss_pkg::CNT_W'(q_desc.has_b)
               + dss_pkg::CNT_W'(q_desc.marker);
  assign last  = (pos + dss_pkg::CNT_W'(1) == total);
  assign load  = q_valid && (!out_valid || token_out.ready);
  assign q_pop = load && last;

  // Held bytes first, then the input byte, or an end marker alone
  always_comb begin
    if (pos < q_desc.sep_cnt) begin
      nxt_byte  = sep[pos[$clog2(dss_pkg::SEP_BYTES)-1:0]];
      nxt_valid = 1'b1;
    end else if (q_desc.has_b) begin
      nxt_byte  = q_desc.data;
      nxt_valid = 1'b1;
    end else begin
      nxt_byte  = 8'd0;
      nxt_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= last ? '0 : pos + dss_pkg::CNT_W'(1);
    end else if (token_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= nxt_byte;
      out_byte_valid <= nxt_valid;
      out_end        <= last && q_desc.closes;
      out_number     <= q_desc.number;
      out_last       <= last;
    end
  end

  assign token_out.valid        = out_valid;
  assign token_out.token_byte   = out_byte;
  assign token_out.byte_valid   = out_byte_valid;
  assign token_out.token_end    = out_end;
  assign token_out.token_number = out_number;
  assign token_out.last_result  = out_last;

  pos_in_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (pos < total))
    else $error("result position past the end of the descriptor");

  pos_rewinds: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (pos == '0))
    else $error("position not rewound after the last result");

endmodule

FILE: src/delimiter_string_splitter.sv
// ----------------------------------------------------------------------------
// delimiter_string_splitter
// Splits a byte stream into tokens at a configurable multi-byte separator.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle whenever its four-entry descriptor
// queue has room, and emits one result per cycle, while the output is
// ready, from a registered output stage. A byte that extends a partial
// separator match produces nothing; a completed separator produces one end
// marker; a mismatch releases the held bytes that no longer start a match
// (and the new byte where it cannot start one), and the end of a buffer all
// held bytes and the new byte, one result per cycle. The output stage sets
// the sustained rate, so input stalls only when the descriptor queue fills.
// The first result of a byte passes through the queue and then the output
// register. Token numbers restart at 0 with each buffer and saturate at
// 2^32-1. Write the separator registers only while the block is idle.
// ----------------------------------------------------------------------------
module delimiter_string_splitter #(
  parameter int MaxSep     = dss_pkg::MAX_SEP,
  parameter int QueueDepth = dss_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dss_pkg::ADDR_W-1:0] paddr,
  input  logic [dss_pkg::DATA_W-1:0] pwdata,
  output logic [dss_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  dss_in_if.sink                     data_in,
  dss_out_if.source                  token_out
);

  dss_pkg::dss_cfg_t  cfg;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_valid;
  dss_pkg::dss_desc_t push_desc;
  dss_pkg::dss_desc_t head_desc;

  dss_regs #(.MaxSep(MaxSep)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dss_front #(.MaxSep(MaxSep)) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .data_in (data_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_desc  (push_desc)
  );

  dss_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  dss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .token_out (token_out)
  );

endmodule

FILE: verif/dss_token_checker.sv
// ----------------------------------------------------------------------------
// dss_token_checker
// Watches the byte input, the token output and the register port of the
// splitter. Keeps its own copy of the separator registers and the match
// state, predicts the token results of every accepted byte and compares
// each delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
module dss_token_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [dss_pkg::ADDR_W-1:0] paddr,
  input  logic [dss_pkg::DATA_W-1:0] pwdata,
  dss_in_if                          data_in,
  dss_out_if                         token_out,
  output int                         mismatches,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  token_byte;
    logic        byte_valid;
    logic        token_end;
    logic [31:0] token_number;
    logic        last_result;
  } token_res_t;

  token_res_t  pending_tokens[$];
  token_res_t  want;
  int          fail_cnt;

  // Shadow of the separator registers
  logic [63:0] sep_lo;
  logic [63:0] sep_hi;
  logic [4:0]  sep_len_reg;

  // Splitter state
  int          held_cnt;
  logic [31:0] tok_num;

  function automatic logic [7:0] sep_at(input int idx);
    if (idx < 8) return sep_lo[8*idx +: 8];
    if (idx < 16) return sep_hi[8*(idx-8) +: 8];
    return 8'h00;
  endfunction

  function automatic int sep_span();
    int l;
    l = sep_len_reg;
    if (l == 0) l = 1;
    if (l > dss_pkg::MAX_SEP) l = dss_pkg::MAX_SEP;
    return l;
  endfunction

  task automatic push_result(input logic [7:0] b, input logic vld, input logic tend,
                             input logic last);
    pending_tokens.push_back(token_res_t'{b, vld, tend, tok_num, last});
  endtask

  task automatic split_byte(input logic [7:0] b, input logic fin);
    logic [7:0] w [dss_pkg::MAX_SEP+1];
    int         len;
    int         m;
    int         n;
    int         k;
    bit         ok;
    len = sep_span();
    m = held_cnt;
    // a shorter separator written mid-buffer cuts the held prefix
    if (m >= len) m = len - 1;
    for (int i = 0; i < m; i++) w[i] = sep_at(i);
    w[m] = b;
    n = m + 1;

    if (b == sep_at(m) && n == len) begin
      push_result(8'h00, 1'b0, 1'b1, 1'b1);
      held_cnt = 0;
      if (fin) tok_num = '0;
      else if (tok_num != 32'hFFFF_FFFF) tok_num = tok_num + 1;
      return;
    end

    if (fin) begin
      for (int i = 0; i < n; i++) push_result(w[i], 1'b1, i == n - 1, i == n - 1);
      held_cnt = 0;
      tok_num = '0;
      return;
    end

    if (b == sep_at(m)) begin
      held_cnt = n;
      return;
    end

    // keep the longest proper suffix that still starts the separator
    k = 0;
    for (int i = m; i >= 1; i--) begin
      ok = 1'b1;
      for (int j = 0; j < i; j++)
        if (w[n-i+j] != sep_at(j)) ok = 1'b0;
      if (ok) begin
        k = i;
        break;
      end
    end
    for (int i = 0; i < n - k; i++) push_result(w[i], 1'b1, 1'b0, i == n - k - 1);
    held_cnt = k;
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", field, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_tokens.delete();
      fail_cnt    = 0;
      sep_lo      = '0;
      sep_hi      = '0;
      sep_len_reg = 5'd1;
      held_cnt    = 0;
      tok_num     = '0;
    end else begin
      if (token_out.valid && token_out.ready) begin
        if (pending_tokens.size() == 0) begin
          $error("token_byte: expected no transaction, got %0h", token_out.token_byte);
          fail_cnt++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_byte", want.token_byte, token_out.token_byte);
          check_field("byte_valid", want.byte_valid, token_out.byte_valid);
          check_field("token_end", want.token_end, token_out.token_end);
          check_field("token_number", want.token_number, token_out.token_number);
          check_field("last_result", want.last_result, token_out.last_result);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[dss_pkg::ADDR_W-1:3])
          dss_pkg::REG_SEP_LOW:  sep_lo = pwdata;
          dss_pkg::REG_SEP_HIGH: sep_hi = pwdata;
          dss_pkg::REG_SEP_LEN:  sep_len_reg = pwdata[4:0];
          default: ;
        endcase
      end
      if (data_in.valid && data_in.ready) split_byte(data_in.data_byte, data_in.buffer_end);
    end
    mismatches  <= fail_cnt;
    outstanding <= pending_tokens.size();
  end

endmodule

FILE: verif/tb_delimiter_string_splitter.sv
// ----------------------------------------------------------------------------
// tb_delimiter_string_splitter
// Stimulus and verdict for the delimiter string splitter. A directed run
// covers empty tokens, fallback on partial matches, separators changed with
// bytes held, short and saturated lengths and the longest release burst;
// random phases then send buffers built from separator fragments under
// several separators and idle/stall patterns. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_delimiter_string_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 25;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [dss_pkg::ADDR_W-1:0] paddr;
  logic [dss_pkg::DATA_W-1:0] pwdata;
  logic [dss_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  dss_in_if  data_in ();
  dss_out_if token_out ();

  int          idle_pct;
  int          stall_pct;
  int          cycle_cnt;
  int          mismatches;
  int          outstanding;
  int          phase_items;
  int          stim_len;
  logic [7:0]  sep_mirror [dss_pkg::SEP_BYTES];

  delimiter_string_splitter DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .data_in   (data_in),
    .token_out (token_out)
  );

  dss_token_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .data_in     (data_in),
    .token_out   (token_out),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    token_out.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dss_pkg::ADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_separator(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len);
    reg_write(dss_pkg::REG_SEP_LOW, lo);
    reg_write(dss_pkg::REG_SEP_HIGH, hi);
    reg_write(dss_pkg::REG_SEP_LEN, 64'(len));
    for (int i = 0; i < 8; i++) begin
      sep_mirror[i]   = lo[8*i +: 8];
      sep_mirror[i+8] = hi[8*i +: 8];
    end
    stim_len = (len == 0) ? 1 : (len > dss_pkg::MAX_SEP) ? dss_pkg::MAX_SEP : len;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      data_in.valid <= 1'b0;
      @(posedge clk);
    end
    data_in.valid      <= 1'b1;
    data_in.data_byte  <= b;
    data_in.buffer_end <= fin;
    do @(posedge clk); while (!data_in.ready);
    phase_items++;
  endtask

  // Drop valid and hold until every predicted transaction has been delivered
  task automatic wait_idle();
    data_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) < 7) return sep_mirror[$urandom_range(stim_len - 1)];
    return 8'($urandom_range(255));
  endfunction

  // One buffer: tokens joined by the separator with stray prefixes, or random bytes
  task automatic run_buffer(input bit close);
    logic [7:0] bytes_q[$];
    int         ntok;
    int         cut;
    ntok = $urandom_range(1, 4);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) bytes_q.push_back(8'($urandom_range(255)));
    end else begin
      for (int t = 0; t < ntok; t++) begin
        repeat ($urandom_range(0, 5)) bytes_q.push_back(pick_byte());
        if (stim_len > 1 && $urandom_range(2) == 0) begin
          cut = $urandom_range(1, stim_len - 1);
          for (int i = 0; i < cut; i++) bytes_q.push_back(sep_mirror[i]);
        end
        if (t < ntok - 1 || $urandom_range(3) == 0)
          for (int i = 0; i < stim_len; i++) bytes_q.push_back(sep_mirror[i]);
      end
    end
    if (bytes_q.size() == 0) bytes_q.push_back(pick_byte());
    foreach (bytes_q[i]) push_byte(bytes_q[i], close && (i == bytes_q.size() - 1));
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    clk                = 1'b0;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    data_in.valid      = 1'b0;
    data_in.data_byte  = 8'h00;
    data_in.buffer_end = 1'b0;
    token_out.ready    = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    stim_len           = 1;
    foreach (sep_mirror[i]) sep_mirror[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset separator is one zero byte: empty first token, close on last byte
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);

    // "abac": fallback keeps "ab" after "abab", then buffer ends on held bytes
    wait_idle();
    set_separator(64'h0000_0000_6361_6261, 64'h0, 5'd4);
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    push_byte("a", 1'b0);
    push_byte("c", 1'b0);
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    push_byte("a", 1'b1);

    // Hold "ab", then shrink the separator to "xy" with the bytes still held
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    wait_idle();
    set_separator(64'h7978, 64'h0, 5'd2);
    push_byte("q", 1'b1);

    // Length zero acts as one
    wait_idle();
    set_separator(64'h7A, 64'h0, 5'd0);
    push_byte("z", 1'b0);
    push_byte("y", 1'b1);

    // Length above the limit saturates; release the longest held prefix
    wait_idle();
    set_separator(64'h0706_0504_0302_01FF, 64'hDEAD_BEEF_CAFE_0908, 5'd16);
    for (int i = 0; i < dss_pkg::MAX_SEP - 1; i++) push_byte(sep_mirror[i], 1'b0);
    push_byte(8'h55, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p % 2 == 0) begin
        for (int i = 0; i < 8; i++) begin
          lo[8*i +: 8] = $urandom_range(1) ? "a" : "b";
          hi[8*i +: 8] = $urandom_range(1) ? "a" : "b";
        end
      end else begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      if (p == 1) begin
        lo = '1;
        hi = '1;
      end else if (p == 5) begin
        lo = '0;
        hi = '0;
      end
      case (p)
        0:       len = 5'd1;
        1:       len = 5'd10;
        2:       len = 5'd16;
        3:       len = 5'd0;
        4:       len = 5'd31;
        5:       len = 5'd3;
        default: len = 5'($urandom_range(2, 10));
      endcase
      set_separator(lo, hi, len);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 75;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 75;
        end
        default: begin
          idle_pct  = 19;
          stall_pct = 19;
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) run_buffer(1'b1);
      // leave a buffer open across the next register change now and then
      if ($urandom_range(2) == 0) run_buffer(1'b0);
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dss_pkg.sv
src/dss_if.sv
src/dss_regs.sv
src/dss_front.sv
src/dss_fifo.sv
src/dss_back.sv
src/delimiter_string_splitter.sv
verif/dss_token_checker.sv
verif/tb_delimiter_string_splitter.sv
